/* hw/rtl/cpes_pkg.sv */
// Package for the cart-pole Euler step block: fixed-point constants, CORDIC
// arctangent table and the saturating Q16.16 helpers. No dependencies.
`default_nettype none
package cpes_pkg;
    localparam int unsigned CordicStagesDefault = 16;
    localparam int unsigned AtanEntries = 30;
    localparam logic signed [31:0] QTwoPi  = 32'sd411775;
    localparam logic signed [31:0] QPi     = 32'sd205887;
    localparam logic signed [31:0] QHalfPi = 32'sd102944;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic [30:0] GravityReset = 31'd642908;
    localparam logic [30:0] InvLenReset  = 31'd65536;
    localparam logic [30:0] StepReset    = 31'd655;

    localparam logic [1:0] RegGravity = 2'd0;
    localparam logic [1:0] RegInvLen  = 2'd1;
    localparam logic [1:0] RegStep    = 2'd2;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg;
    } t_rot;

    function automatic logic signed [33:0] atan_q30(input int unsigned idx);
        logic signed [33:0] r;
        case (idx)
            0: r = 34'sd843314857;   1: r = 34'sd497837829;
            2: r = 34'sd263043837;   3: r = 34'sd133525159;
            4: r = 34'sd67021687;    5: r = 34'sd33543516;
            6: r = 34'sd16775851;    7: r = 34'sd8388437;
            8: r = 34'sd4194283;     9: r = 34'sd2097149;
            default: r = (idx < 30) ? (34'sd1 <<< (30 - idx)) : 34'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'h7fffffff;
        else if (v < -66'sd2147483648) r = 32'h80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Q16.16 product with floor rounding and saturation.
    function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return sat32(p >>> 16);
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/cpes_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface cpes_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cpes_cell.sv */
// One CORDIC rotation cell of the pipeline chain with its side payload.
// Depends on cpes_pkg.
`default_nettype none
module cpes_cell import cpes_pkg::*; #(
    parameter int unsigned Stage = 0,
    parameter int unsigned PayW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire t_rot            i_rot,
    input  wire logic [PayW-1:0] i_pay,
    output t_rot                 o_rot,
    output logic [PayW-1:0]      o_pay
);
    t_rot n_rot;
    t_rot r_rot;
    logic [PayW-1:0] r_pay;

    always_comb begin
        n_rot = i_rot;
        if (i_rot.z >= 0) begin
            n_rot.x = i_rot.x - (i_rot.y >>> Stage);
            n_rot.y = i_rot.y + (i_rot.x >>> Stage);
            n_rot.z = i_rot.z - atan_q30(Stage);
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> Stage);
            n_rot.y = i_rot.y - (i_rot.x >>> Stage);
            n_rot.z = i_rot.z + atan_q30(Stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
            r_pay <= i_pay;
        end
    end
    assign o_rot = r_rot;
    assign o_pay = r_pay;
endmodule
`default_nettype wire

/* hw/rtl/cart_pole_euler_step_top.sv */
// Cart-pole Euler step: angle reduction, CORDIC chain, dynamics pipeline.
// Depends on cpes_pkg, cpes_if and cpes_cell.
// One request is accepted every cycle while the output is not stalled.
// The whole pipeline advances together when the output slot is free or taken.
// Reset (synchronous, active low) clears all valid bits and loads the default
// gravity, inverse length and time step.
`default_nettype none
module cart_pole_euler_step_top import cpes_pkg::*; #(
    parameter int unsigned CORDIC_STAGES = CordicStagesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data,
    cpes_if.sink             s_in,
    cpes_if.source           m_out
);
    // Pipeline depth: stages 0-2 reduce the angle, then the CORDIC cells,
    // then five stages of products and sums.
    localparam int unsigned NCell = (CORDIC_STAGES < AtanEntries) ?
                                    CORDIC_STAGES : AtanEntries;
    localparam int unsigned Depth = NCell + 8;
    localparam int unsigned PayW = 128;

    logic [30:0] r_g, r_h, r_dt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g <= GravityReset; r_h <= InvLenReset; r_dt <= StepReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegGravity: r_g  <= i_cfg_data;
                RegInvLen:  r_h  <= i_cfg_data;
                RegStep:    r_dt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global stall: everything moves when the output register can take data.
    logic [Depth-1:0] r_v;
    logic adv;
    assign adv = !m_out.valid || m_out.ready;
    assign s_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[Depth-2:0], s_in.valid};
    end

    // Input payload fields.
    logic signed [31:0] in_a, in_w, in_p, in_v, in_u;
    assign {in_a, in_w, in_p, in_v, in_u} = s_in.data;

    // Stage A: floor modulo two pi as a 48-bit remainder via a small quotient.
    // Quotient estimate by reciprocal multiply, corrected over two stages.
    logic signed [31:0] r_a0;
    logic signed [47:0] r_q0;
    logic [PayW-1:0] r_pay0;
    // 2^32/411775 ~ 10430.374; use 10430 then correct (error < 3 steps).
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a0 <= in_a;
            r_q0 <= 48'((64'(in_a) * 64'sd10430) >>> 32);
            r_pay0 <= {in_w, in_p, in_v, in_u};
        end
    end

    logic signed [47:0] rem0;
    assign rem0 = 48'(r_a0) - r_q0 * 48'(QTwoPi);
    logic signed [47:0] r_rem1;
    logic signed [31:0] r_a1;
    logic [PayW-1:0] r_pay1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem1 <= rem0;
            r_a1 <= r_a0;
            r_pay1 <= r_pay0;
        end
    end

    // Bring remainder into [0, two pi), then fold.
    logic signed [47:0] rm;
    logic signed [47:0] rr;
    logic negf;
    always_comb begin
        rm = r_rem1;
        for (int k = 0; k < 4; k++) begin
            if (rm < 0) rm = rm + 48'(QTwoPi);
            else if (rm >= 48'(QTwoPi)) rm = rm - 48'(QTwoPi);
        end
        rr = rm;
        if (rr > 48'(QPi)) rr = rr - 48'(QTwoPi);
        negf = 1'b0;
        if (rr > 48'(QHalfPi)) begin
            rr = rr - 48'(QPi); negf = 1'b1;
        end else if (rr < -48'(QHalfPi)) begin
            rr = rr + 48'(QPi); negf = 1'b1;
        end
    end

    t_rot r_rot2;
    logic signed [31:0] r_a2;
    logic [PayW-1:0] r_pay2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rot2.x <= CordicGain;
            r_rot2.y <= '0;
            r_rot2.z <= 34'(rr) <<< 14;
            r_rot2.neg <= negf;
            r_a2 <= r_a1;
            r_pay2 <= r_pay1;
        end
    end

    // CORDIC chain; the angle rides along in the payload.
    t_rot rot_c [NCell+1];
    logic [PayW+31:0] pay_c [NCell+1];
    assign rot_c[0] = r_rot2;
    assign pay_c[0] = {r_a2, r_pay2};
    for (genvar i = 0; i < NCell; i++) begin : g_cell
        cpes_cell #(.Stage(i), .PayW(PayW + 32)) u_cell (
            .i_clk(i_clk), .i_en(adv), .i_rot(rot_c[i]), .i_pay(pay_c[i]),
            .o_rot(rot_c[i+1]), .o_pay(pay_c[i+1]));
    end

    logic signed [31:0] ca, cw, cp, cv, cu;
    assign {ca, cw, cp, cv, cu} = pay_c[NCell];
    logic signed [33:0] sx, sy;
    assign sx = (rot_c[NCell].x + 34'sd8192) >>> 14;
    assign sy = (rot_c[NCell].y + 34'sd8192) >>> 14;

    // Stage D1: sin/cos, gravity over length, kinematic products.
    logic signed [31:0] r_s, r_c, r_gl, r_na, r_np, r_nv;
    logic signed [31:0] r_w3, r_u3;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s <= rot_c[NCell].neg ? 32'(-sy) : 32'(sy);
            r_c <= rot_c[NCell].neg ? 32'(-sx) : 32'(sx);
            r_gl <= qmul({2'b0, r_g}, {2'b0, r_h});
            r_na <= sat32(66'(ca) + 66'(qmul({2'b0, r_dt}, 33'(cw))));
            r_np <= sat32(66'(cp) + 66'(qmul({2'b0, r_dt}, 33'(cv))));
            r_nv <= sat32(66'(cv) + 66'(qmul({2'b0, r_dt}, 33'(cu))));
            r_w3 <= cw; r_u3 <= cu;
        end
    end

    // Stage D2: length-scaled sin/cos and gravity terms.
    logic signed [31:0] r_ch, r_sh, r_gs, r_gc, r_na4, r_np4, r_nv4, r_w4, r_u4;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ch <= qmul(33'(r_c), {2'b0, r_h});
            r_sh <= qmul(33'(r_s), {2'b0, r_h});
            r_gs <= qmul(33'(r_gl), 33'(r_s));
            r_gc <= qmul(33'(r_gl), 33'(r_c));
            r_na4 <= r_na; r_np4 <= r_np; r_nv4 <= r_nv;
            r_w4 <= r_w3; r_u4 <= r_u3;
        end
    end

    // Stage D3: command products.
    logic signed [31:0] r_uc, r_us, r_gs5, r_gc5, r_ch5, r_na5, r_np5, r_nv5, r_w5;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_uc <= qmul(33'(r_u4), 33'(r_ch));
            r_us <= qmul(33'(r_u4), 33'(r_sh));
            r_gs5 <= r_gs; r_gc5 <= r_gc; r_ch5 <= r_ch;
            r_na5 <= r_na4; r_np5 <= r_np4; r_nv5 <= r_nv4; r_w5 <= r_w4;
        end
    end

    // Stage D4: acceleration and Jacobian sums.
    logic signed [31:0] r_acc, r_jac, r_ch6, r_na6, r_np6, r_nv6, r_w6;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_acc <= sat32(66'(r_gs5) + 66'(r_uc));
            r_jac <= sat32(66'(r_gc5) - 66'(r_us));
            r_ch6 <= r_ch5; r_na6 <= r_na5; r_np6 <= r_np5;
            r_nv6 <= r_nv5; r_w6 <= r_w5;
        end
    end

    // Stage D5 (output register): angle rate update.
    logic [223:0] r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= {r_na6,
                      sat32(66'(r_w6) + 66'(qmul({2'b0, r_dt}, 33'(r_acc)))),
                      r_np6, r_nv6, r_acc, r_jac, r_ch6};
        end
    end
    assign m_out.valid = r_v[Depth-1];
    assign m_out.data  = r_out;

    // A stalled output keeps its valid flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid)
        else $error("output dropped while stalled");
    // Input is refused only when the output is stalled.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_in.ready |-> m_out.valid && !m_out.ready)
        else $error("input refused without backpressure");
    // Accepted request reaches the first stage.
    a_ent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready |=> r_v[0])
        else $error("accepted request lost");
endmodule
`default_nettype wire
